// ===== rtl/irs_pkg.sv =====
// irs_pkg: shared types, constants and helper functions for the image resize engine.
// No dependencies; imported by every module under rtl/.
`default_nettype none
package irs_pkg;

	// Frame store geometry
	localparam int unsigned MAX_WIDTH    = 256;
	localparam int unsigned MAX_HEIGHT   = 256;
	localparam int unsigned MAX_CHANNELS = 4;

	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
	localparam int unsigned CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned ADDR_W = CH_W + ROW_W + COL_W;
	localparam int unsigned STORE_DEPTH = 1 << ADDR_W;

	// Field widths
	localparam int unsigned COORD_W = 12;
	localparam int unsigned CHF_W   = 2;
	localparam int unsigned VAL_W   = 8;
	localparam int unsigned DIM_W   = 9;
	localparam int unsigned CCNT_W  = 3;
	localparam int unsigned SCALE_W = 20;

	// Fixed point
	localparam int unsigned PROD_W = COORD_W + 1 + SCALE_W; // (2*coord+1)*scale
	localparam int unsigned Q_W    = PROD_W + 1;            // position + 1.0 in Q.17
	localparam int unsigned IDX_W  = Q_W - 17;              // integer part of Q.17
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned WGT_W  = 33;                    // Q0.32 weight, up to 1.0
	localparam int unsigned ACC_W  = VAL_W + WGT_W;
	localparam int unsigned HALF_Q17 = 65536;
	localparam int unsigned ONE_Q16  = 65536;
	localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << 32;
	localparam logic [ACC_W-1:0] ACC_HALF = ACC_W'(1) << 31;
	localparam logic [ACC_W-1:0] ACC_MAX  = ACC_W'(255) << 32;

	// Queue sizes
	localparam int unsigned CMDQ_DEPTH = 8;
	localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int unsigned OUTQ_DEPTH = 8;
	localparam int unsigned OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
	localparam int unsigned OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// Register map
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = SCALE_W;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE       = 3'd5;

	// Item codes
	localparam logic REQ_LOAD      = 1'b0;
	localparam logic REQ_PIXEL     = 1'b1;
	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_NEAR,
		OP_BILIN
	} irs_op_e;

	typedef struct packed {
		logic                 req_type;
		logic [COORD_W-1:0]   pixel_col;
		logic [COORD_W-1:0]   pixel_row;
		logic [CHF_W-1:0]     pixel_channel;
		logic [VAL_W-1:0]     load_value;
	} irs_req_t;

	typedef struct packed {
		logic [VAL_W-1:0]     result_value;
		logic [COORD_W-1:0]   result_col;
		logic [COORD_W-1:0]   result_row;
		logic [CHF_W-1:0]     result_channel;
	} irs_rsp_t;

	typedef struct packed {
		logic [COORD_W-1:0]   col;
		logic [COORD_W-1:0]   row;
		logic [CHF_W-1:0]     ch;
	} irs_tag_t;

	typedef struct packed {
		logic [DIM_W-1:0]     source_width;
		logic [DIM_W-1:0]     source_height;
		logic [CCNT_W-1:0]    channel_count;
		logic                 interp_mode;
		logic [SCALE_W-1:0]   x_scale;
		logic [SCALE_W-1:0]   y_scale;
	} irs_cfg_t;

	typedef struct packed {
		irs_op_e                   op;
		logic [3:0][ADDR_W-1:0]    addr;
		logic [3:0][WGT_W-1:0]     weight;
		logic [VAL_W-1:0]          load_value;
		irs_tag_t                  tag;
	} irs_cmd_t;

	// Effective size minus one: zero counts as one, capped at the store size.
	function automatic logic [IDX_W-1:0] eff_m1(input logic [DIM_W-1:0] v,
			input logic [IDX_W-1:0] maxv);
		logic [IDX_W-1:0] ve;
		ve = IDX_W'(v);
		if (v == '0)
			return '0;
		else if (ve > maxv)
			return maxv - IDX_W'(1);
		else
			return ve - IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v,
			input logic [IDX_W-1:0] lim);
		return (v > lim) ? lim : v;
	endfunction

	function automatic logic [ADDR_W-1:0] mk_addr(input logic [IDX_W-1:0] ch,
			input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
		return {ch[CH_W-1:0], row[ROW_W-1:0], col[COL_W-1:0]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/irs_front.sv =====
// irs_front: accepts items, maps requests to source positions, clamps and
// builds read lists with weights. Depends on irs_pkg.
`default_nettype none
module irs_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire irs_pkg::irs_cfg_t             cfg,
	input  wire logic                          push,
	input  wire irs_pkg::irs_req_t             req,
	output logic                               full,
	input  wire logic [irs_pkg::CMDQ_CNT_W-1:0] q_count,
	output logic                               cmd_push,
	output irs_pkg::irs_cmd_t                  cmd
);
	import irs_pkg::*;

	logic                 v_s1, v_s2, v_s3;
	irs_req_t             req_s1, req_s2;
	logic [PROD_W-1:0]    prodx_s2, prody_s2;
	irs_op_e              op_s3;
	logic [3:0][ADDR_W-1:0] addr_s3;
	logic [FRAC_W-1:0]    dx_s3, dy_s3;
	logic [VAL_W-1:0]     val_s3;
	irs_tag_t             tag_s3;

	logic                 accept;
	logic [CMDQ_CNT_W:0]  used;

	// credit: queue entries plus items still in flight here
	assign used = (CMDQ_CNT_W+1)'(q_count) + (CMDQ_CNT_W+1)'(v_s1)
		+ (CMDQ_CNT_W+1)'(v_s2) + (CMDQ_CNT_W+1)'(v_s3);
	assign full   = used >= (CMDQ_CNT_W+1)'(CMDQ_DEPTH);
	assign accept = push && !full;

	// stage 1: capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// stage 2: (2*coord+1)*scale
	logic [PROD_W-1:0] prodx, prody;
	assign prodx = PROD_W'({req_s1.pixel_col, 1'b1}) * PROD_W'(cfg.x_scale);
	assign prody = PROD_W'({req_s1.pixel_row, 1'b1}) * PROD_W'(cfg.y_scale);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			req_s2   <= req_s1;
			prodx_s2 <= prodx;
			prody_s2 <= prody;
		end
	end

	// stage 3: floor / round, clamp, fractions
	logic [Q_W-1:0]   qx, qy;
	logic [IDX_W-1:0] ux, uy, nx, ny;
	logic [IDX_W-1:0] wm1, hm1, cm1;
	logic [IDX_W-1:0] cx1, cx2, cy1, cy2, ncx, ncy, cr;
	logic [IDX_W-1:0] lc, lr, lch;
	logic             load_ok, keep;
	irs_op_e          op_n;
	logic [3:0][ADDR_W-1:0] addr_n;

	always_comb begin
		wm1 = eff_m1(cfg.source_width, IDX_W'(MAX_WIDTH));
		hm1 = eff_m1(cfg.source_height, IDX_W'(MAX_HEIGHT));
		cm1 = eff_m1(DIM_W'(cfg.channel_count), IDX_W'(MAX_CHANNELS));

		// q = position + 1.0 in Q.17, so floor = q[int] - 1
		qx = Q_W'(prodx_s2) + Q_W'(HALF_Q17);
		qy = Q_W'(prody_s2) + Q_W'(HALF_Q17);
		ux = qx[Q_W-1:17];
		uy = qy[Q_W-1:17];
		// half away from zero: negative positions round to 0 or -1, both clamp to 0
		nx = IDX_W'(prodx_s2[PROD_W-1:17]);
		ny = IDX_W'(prody_s2[PROD_W-1:17]);

		cx1 = (ux == '0) ? '0 : clamp_idx(ux - IDX_W'(1), wm1);
		cx2 = clamp_idx(ux, wm1);
		cy1 = (uy == '0) ? '0 : clamp_idx(uy - IDX_W'(1), hm1);
		cy2 = clamp_idx(uy, hm1);
		ncx = clamp_idx(nx, wm1);
		ncy = clamp_idx(ny, hm1);
		cr  = clamp_idx(IDX_W'(req_s2.pixel_channel), cm1);

		lc  = IDX_W'(req_s2.pixel_col);
		lr  = IDX_W'(req_s2.pixel_row);
		lch = IDX_W'(req_s2.pixel_channel);
		load_ok = (lc < IDX_W'(MAX_WIDTH)) && (lr < IDX_W'(MAX_HEIGHT))
			&& (lch < IDX_W'(MAX_CHANNELS));

		addr_n = '0;
		if (req_s2.req_type == REQ_LOAD) begin
			op_n      = OP_LOAD;
			keep      = load_ok;
			addr_n[0] = mk_addr(lch, lr, lc);
		end else if (cfg.interp_mode == MODE_NEAREST) begin
			op_n      = OP_NEAR;
			keep      = 1'b1;
			addr_n[0] = mk_addr(cr, ncy, ncx);
		end else begin
			op_n      = OP_BILIN;
			keep      = 1'b1;
			addr_n[0] = mk_addr(cr, cy1, cx1);
			addr_n[1] = mk_addr(cr, cy1, cx2);
			addr_n[2] = mk_addr(cr, cy2, cx1);
			addr_n[3] = mk_addr(cr, cy2, cx2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2 && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			op_s3   <= op_n;
			addr_s3 <= addr_n;
			dx_s3   <= qx[16:1];
			dy_s3   <= qy[16:1];
			val_s3  <= req_s2.load_value;
			tag_s3  <= '{col: req_s2.pixel_col, row: req_s2.pixel_row,
				ch: req_s2.pixel_channel};
		end
	end

	// weights: products of the Q0.16 fractions, Q0.32
	logic [FRAC_W:0]    ix, iy, dxe, dye;
	logic [2*FRAC_W+1:0] w00, w01, w10, w11;

	always_comb begin
		dxe = (FRAC_W+1)'(dx_s3);
		dye = (FRAC_W+1)'(dy_s3);
		ix  = (FRAC_W+1)'(ONE_Q16) - dxe;
		iy  = (FRAC_W+1)'(ONE_Q16) - dye;
		w00 = (2*FRAC_W+2)'(ix) * (2*FRAC_W+2)'(iy);
		w01 = (2*FRAC_W+2)'(dxe) * (2*FRAC_W+2)'(iy);
		w10 = (2*FRAC_W+2)'(ix) * (2*FRAC_W+2)'(dye);
		w11 = (2*FRAC_W+2)'(dxe) * (2*FRAC_W+2)'(dye);

		cmd.op         = op_s3;
		cmd.addr       = addr_s3;
		cmd.load_value = val_s3;
		cmd.tag        = tag_s3;
		if (op_s3 == OP_BILIN) begin
			cmd.weight[0] = w00[WGT_W-1:0];
			cmd.weight[1] = w01[WGT_W-1:0];
			cmd.weight[2] = w10[WGT_W-1:0];
			cmd.weight[3] = w11[WGT_W-1:0];
		end else begin
			cmd.weight    = '0;
			cmd.weight[0] = WGT_ONE;
		end
	end

	assign cmd_push = v_s3;

endmodule
`default_nettype wire

// ===== rtl/irs_cmdq.sv =====
// irs_cmdq: short command queue that decouples the front and back parts.
// Depends on irs_pkg.
`default_nettype none
module irs_cmdq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           push,
	input  wire irs_pkg::irs_cmd_t              cmd_in,
	input  wire logic                           pop,
	output irs_pkg::irs_cmd_t                   head,
	output logic                                head_valid,
	output logic [irs_pkg::CMDQ_CNT_W-1:0]      count
);
	import irs_pkg::*;

	irs_cmd_t                entry_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0]   wr_q, rd_q;
	logic [CMDQ_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + CMDQ_PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + CMDQ_PTR_W'(1);
			cnt_q <= cnt_q + CMDQ_CNT_W'(push) - CMDQ_CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= cmd_in;
		end
	end

	assign head       = entry_q[rd_q];
	assign head_valid = cnt_q != '0;
	assign count      = cnt_q;

endmodule
`default_nettype wire

// ===== rtl/irs_back.sv =====
// irs_back: frame store, read sequencer, multiply-accumulate and result queue.
// Depends on irs_pkg.
`default_nettype none
module irs_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire irs_pkg::irs_cmd_t cmd,
	input  wire logic              cmd_valid,
	output logic                   cmd_pop,
	input  wire logic              pop,
	output logic                   empty,
	output irs_pkg::irs_rsp_t      rsp
);
	import irs_pkg::*;

	logic [VAL_W-1:0]        store [STORE_DEPTH];

	logic [1:0]              step_q;
	logic                    v_s1, first_s1, last_s1;
	logic [WGT_W-1:0]        w_s1;
	irs_tag_t                tag_s1;
	logic [VAL_W-1:0]        rdata_s1;
	logic                    v_s2, first_s2, last_s2;
	logic [ACC_W-1:0]        prod_s2;
	irs_tag_t                tag_s2;
	logic                    rv_s3;
	logic [ACC_W-1:0]        acc_s3;
	irs_tag_t                tag_s3;

	irs_rsp_t                outq_q [OUTQ_DEPTH];
	logic [OUTQ_PTR_W-1:0]   owr_q, ord_q;
	logic [OUTQ_CNT_W-1:0]   ocnt_q;

	// sequencer
	logic                    is_load, issue, last, mem_we, credit_ok, opop;
	logic [1:0]              nreads_m1;
	logic [ADDR_W-1:0]       mem_addr;
	logic [OUTQ_CNT_W:0]     oused;

	always_comb begin
		unique case (cmd.op)
			OP_LOAD:  nreads_m1 = 2'd0;
			OP_NEAR:  nreads_m1 = 2'd0;
			OP_BILIN: nreads_m1 = 2'd3;
			default:  nreads_m1 = 2'd0;
		endcase
	end

	// results still in the pipe reserve their slot in the result queue
	assign oused = (OUTQ_CNT_W+1)'(ocnt_q) + (OUTQ_CNT_W+1)'(v_s1 && last_s1)
		+ (OUTQ_CNT_W+1)'(v_s2 && last_s2) + (OUTQ_CNT_W+1)'(rv_s3);
	assign credit_ok = oused < (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
	assign is_load   = cmd.op == OP_LOAD;
	assign mem_we    = cmd_valid && is_load;
	assign issue     = cmd_valid && !is_load && credit_ok;
	assign last      = step_q == nreads_m1;
	assign cmd_pop   = mem_we || (issue && last);
	assign mem_addr  = cmd.addr[step_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (issue) begin
			step_q <= last ? 2'd0 : step_q + 2'd1;
		end
	end

	// single-port store, registered read
	always_ff @(posedge clk) begin
		if (mem_we)
			store[mem_addr] <= cmd.load_value;
		rdata_s1 <= store[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			rv_s3 <= 1'b0;
		end else begin
			v_s1  <= issue;
			v_s2  <= v_s1;
			rv_s3 <= v_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			first_s1 <= step_q == 2'd0;
			last_s1  <= last;
			w_s1     <= cmd.weight[step_q];
			tag_s1   <= cmd.tag;
		end
		if (v_s1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			prod_s2  <= ACC_W'(rdata_s1) * ACC_W'(w_s1);
			tag_s2   <= tag_s1;
		end
		if (v_s2) begin
			acc_s3 <= first_s2 ? prod_s2 : acc_s3 + prod_s2;
			tag_s3 <= tag_s2;
		end
	end

	// round half up, drop Q.32, saturate
	logic [ACC_W-1:0]    rnd;
	logic [ACC_W-33:0]   vq;
	irs_rsp_t            res;

	always_comb begin
		rnd = acc_s3 + ACC_HALF;
		vq  = rnd[ACC_W-1:32];
		res.result_value   = (vq > (ACC_W-32)'(255)) ? 8'hFF : vq[VAL_W-1:0];
		res.result_col     = tag_s3.col;
		res.result_row     = tag_s3.row;
		res.result_channel = tag_s3.ch;
	end

	// result queue
	assign opop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (rv_s3)
				owr_q <= (owr_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_q + OUTQ_PTR_W'(1);
			if (opop)
				ord_q <= (ord_q == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_q + OUTQ_PTR_W'(1);
			ocnt_q <= ocnt_q + OUTQ_CNT_W'(rv_s3) - OUTQ_CNT_W'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (rv_s3)
			outq_q[owr_q] <= res;
	end

	assign empty = ocnt_q == '0;
	assign rsp   = outq_q[ord_q];

	a_outq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s3 |-> ocnt_q != OUTQ_CNT_W'(OUTQ_DEPTH))
		else $error("result queue overflow");

	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_weights_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rv_s3 |-> acc_s3 <= ACC_MAX)
		else $error("blend sum exceeds full scale");

endmodule
`default_nettype wire

// ===== rtl/image_resize_nn_bilinear.sv =====
// image_resize_nn_bilinear: top level; config registers, front, command queue, back.
// Depends on irs_pkg, irs_front, irs_cmdq, irs_back.
// Throughput: loads 1 per cycle; nearest requests 1 per cycle while the result queue has
// room; bilinear items make four reads each, one read per cycle on the single frame store
// port while the result queue has room. Reset clears control state and config to its
// defaults; the frame store is not cleared and holds garbage until loaded.
`default_nettype none
module image_resize_nn_bilinear (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// input queue side
	input  wire logic                          push,
	output logic                               full,
	input  wire irs_pkg::irs_req_t             req,
	// result queue side
	output logic                               empty,
	input  wire logic                          pop,
	output irs_pkg::irs_rsp_t                  rsp,
	// register writes
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [irs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [irs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import irs_pkg::*;

	// Config registers. Write them only while idle (not enforced here); the front reads them live.
	irs_cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width  <= DIM_W'(256);
			cfg_q.source_height <= DIM_W'(256);
			cfg_q.channel_count <= CCNT_W'(3);
			cfg_q.interp_mode   <= MODE_NEAREST;
			cfg_q.x_scale       <= SCALE_W'(65536);
			cfg_q.y_scale       <= SCALE_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_data[DIM_W-1:0];
				CFG_SOURCE_HEIGHT: cfg_q.source_height <= cfg_data[DIM_W-1:0];
				CFG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CCNT_W-1:0];
				CFG_INTERP_MODE:   cfg_q.interp_mode   <= cfg_data[0];
				CFG_X_SCALE:       cfg_q.x_scale       <= cfg_data[SCALE_W-1:0];
				CFG_Y_SCALE:       cfg_q.y_scale       <= cfg_data[SCALE_W-1:0];
				default: ; // unmapped index: transfer accepted and dropped
			endcase
		end
	end

	// Front: position math and clamping, three stages. It takes an item only when
	// the command queue has room for it and everything already in its stages.
	logic                  cmd_push;
	irs_cmd_t              cmd_in;
	logic [CMDQ_CNT_W-1:0] q_count;

	irs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.req      (req),
		.full     (full),
		.q_count  (q_count),
		.cmd_push (cmd_push),
		.cmd      (cmd_in)
	);

	// Command queue: lets the front run on while the back makes the four reads
	// of a bilinear item, and holds ordering between loads and requests.
	irs_cmd_t head;
	logic     head_valid;
	logic     cmd_pop;

	irs_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (cmd_push),
		.cmd_in     (cmd_in),
		.pop        (cmd_pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (q_count)
	);

	// Back: frame store writes and reads, weighted sum, rounding and the result
	// queue that keeps results waiting while new items still flow in.
	irs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (head),
		.cmd_valid (head_valid),
		.cmd_pop   (cmd_pop),
		.pop       (pop),
		.empty     (empty),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== tb/sv/image_resize_nn_bilinear_tb.sv =====
`timescale 1ns / 1ps
// image_resize_nn_bilinear_tb: self-checking bench for the resize engine (load + nearest/bilinear).
// Depends on irs_pkg and image_resize_nn_bilinear; needs nothing else.
module image_resize_nn_bilinear_tb;
	import irs_pkg::*;

	localparam int RESET_CYCLES = 5;
	localparam int SETTLE_CYCLES = 24;      // lets the pipeline run dry after the last item, with margin
	localparam int STALL_LIMIT = 2000;      // cycles with no transfer at all before giving up
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 205;
	localparam longint HALF_POS = 65536;    // 0.5 in Q.17
	localparam longint ONE_POS = 131072;    // 1.0 in Q.17
	localparam longint unsigned ONE_WGT = 65536;
	localparam longint unsigned ROUND_HALF = 64'd1 << 31;
	localparam longint unsigned VALUE_MAX = 255;
	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_Y_SCALE + 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_Y_SCALE + 3'd2;

	// Source positions read for one output pixel, each with its Q0.32 weight.
	typedef struct packed {
		logic [2:0]                count;
		logic [3:0][ADDR_W-1:0]    addr;
		logic [3:0][WGT_W-1:0]     wgt;
	} tap_set_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	irs_req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	irs_rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	irs_cfg_t active_cfg;                   // register contents as the block should hold them
	logic [VAL_W-1:0] frame_shadow [STORE_DEPTH];  // store contents, updated at transfer
	bit frame_filled [STORE_DEPTH];         // entries already loaded by queued stimulus
	irs_req_t pending_items[$];
	irs_rsp_t expected_pixels[$];
	int error_count = 0;
	bit calm = 1'b0;                        // no idling on either side once set
	int send_gap = 0;
	int recv_gap = 0;
	int quiet_cycles = 0;

	image_resize_nn_bilinear DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.req       (req),
		.empty     (empty),
		.pop       (pop),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Resampling arithmetic
	// ---------------------------------------------------------------------------------

	// Register value to usable size: zero means one, anything past the store is capped.
	function automatic longint unsigned eff_extent(longint unsigned v, longint unsigned cap);
		if (v == 0)
			return 1;
		return (v > cap) ? cap : v;
	endfunction

	function automatic longint floor_pos(longint p);
		if (p >= 0)
			return p >>> 17;
		return -((-p + ONE_POS - 1) >>> 17);
	endfunction

	// Half away from zero
	function automatic longint round_pos(longint p);
		if (p >= 0)
			return (p + HALF_POS) >>> 17;
		return -((-p + HALF_POS) >>> 17);
	endfunction

	function automatic longint unsigned edge_clamp(longint v, longint unsigned n);
		if (v < 0)
			return 0;
		if (v >= longint'(n))
			return n - 1;
		return v;
	endfunction

	function automatic logic [ADDR_W-1:0] frame_index(longint unsigned ch, longint unsigned row,
			longint unsigned col);
		return ADDR_W'((ch * MAX_HEIGHT + row) * MAX_WIDTH + col);
	endfunction

	// Map an output pixel to the source entries it reads.
	// Position is (2*coord + 1) * scale - 0.5 in Q.17, i.e. (coord + 0.5) * scale - 0.5.
	function automatic tap_set_t source_taps(irs_cfg_t c, irs_req_t r);
		longint unsigned w, h, nc, cr, dx, dy, ix, iy, cx1, cx2, cy1, cy2;
		longint px, py, x1, y1;
		tap_set_t t;
		t = '0;
		w = eff_extent(c.source_width, MAX_WIDTH);
		h = eff_extent(c.source_height, MAX_HEIGHT);
		nc = eff_extent(c.channel_count, MAX_CHANNELS);
		// channel past the configured count reads the last one; the tag still echoes it
		cr = (r.pixel_channel < nc) ? r.pixel_channel : nc - 1;
		px = (2 * longint'(r.pixel_col) + 1) * longint'(c.x_scale) - HALF_POS;
		py = (2 * longint'(r.pixel_row) + 1) * longint'(c.y_scale) - HALF_POS;
		if (c.interp_mode == MODE_NEAREST) begin
			t.count = 3'd1;
			t.addr[0] = frame_index(cr, edge_clamp(round_pos(py), h),
				edge_clamp(round_pos(px), w));
			t.wgt[0] = WGT_ONE;
		end else begin
			x1 = floor_pos(px);
			y1 = floor_pos(py);
			// fraction truncated from Q0.17 to Q0.16
			dx = (px - x1 * ONE_POS) >>> 1;
			dy = (py - y1 * ONE_POS) >>> 1;
			ix = ONE_WGT - dx;
			iy = ONE_WGT - dy;
			cx1 = edge_clamp(x1, w);
			cx2 = edge_clamp(x1 + 1, w);
			cy1 = edge_clamp(y1, h);
			cy2 = edge_clamp(y1 + 1, h);
			t.count = 3'd4;
			t.addr[0] = frame_index(cr, cy1, cx1);
			t.addr[1] = frame_index(cr, cy1, cx2);
			t.addr[2] = frame_index(cr, cy2, cx1);
			t.addr[3] = frame_index(cr, cy2, cx2);
			t.wgt[0] = WGT_W'(ix * iy);
			t.wgt[1] = WGT_W'(dx * iy);
			t.wgt[2] = WGT_W'(ix * dy);
			t.wgt[3] = WGT_W'(dx * dy);
		end
		return t;
	endfunction

	function automatic bit in_store(irs_req_t r);
		return r.pixel_col < MAX_WIDTH && r.pixel_row < MAX_HEIGHT &&
			r.pixel_channel < MAX_CHANNELS;
	endfunction

	// Apply one accepted item: loads update the store copy, requests queue a pixel.
	function automatic void predict_transfer(irs_req_t r);
		tap_set_t t;
		longint unsigned acc;
		irs_rsp_t px;
		if (r.req_type == REQ_LOAD) begin
			if (in_store(r))
				frame_shadow[frame_index(r.pixel_channel, r.pixel_row, r.pixel_col)] =
					r.load_value;
		end else begin
			t = source_taps(active_cfg, r);
			acc = 0;
			for (int i = 0; i < t.count; i++)
				acc += longint'(frame_shadow[t.addr[i]]) * longint'(t.wgt[i]);
			acc = (acc + ROUND_HALF) >> 32;
			if (acc > VALUE_MAX)
				acc = VALUE_MAX;
			px.result_value = VAL_W'(acc);
			px.result_col = r.pixel_col;
			px.result_row = r.pixel_row;
			px.result_channel = r.pixel_channel;
			expected_pixels.push_back(px);
		end
	endfunction

	// ---------------------------------------------------------------------------------
	// Stimulus generation
	// ---------------------------------------------------------------------------------

	// Returns 1 for a load that lands in the store, 0 for one the block drops.
	function automatic int queue_load(int col, int row, int ch, int val);
		irs_req_t r;
		r.req_type = REQ_LOAD;
		r.pixel_col = COORD_W'(col);
		r.pixel_row = COORD_W'(row);
		r.pixel_channel = CHF_W'(ch);
		r.load_value = VAL_W'(val);
		pending_items.push_back(r);
		if (!in_store(r))
			return 0;
		frame_filled[frame_index(r.pixel_channel, r.pixel_row, r.pixel_col)] = 1'b1;
		return 1;
	endfunction

	// Queue a request, first loading any source entry it touches that was never written
	// (even at zero weight: the block still reads all four taps).
	function automatic int queue_pixel(int col, int row, int ch);
		irs_req_t r;
		tap_set_t t;
		int made;
		int a;
		made = 1;
		r.req_type = REQ_PIXEL;
		r.pixel_col = COORD_W'(col);
		r.pixel_row = COORD_W'(row);
		r.pixel_channel = CHF_W'(ch);
		r.load_value = VAL_W'($urandom_range(0, 255));
		t = source_taps(active_cfg, r);
		for (int i = 0; i < t.count; i++) begin
			if (!frame_filled[t.addr[i]]) begin
				a = t.addr[i];
				made += queue_load(a % MAX_WIDTH, (a / MAX_WIDTH) % MAX_HEIGHT,
					a / (MAX_WIDTH * MAX_HEIGHT), $urandom_range(0, 255));
			end
		end
		pending_items.push_back(r);
		return made;
	endfunction

	// Mostly small output coordinates, some over the whole field, some at its ends.
	function automatic int pick_coord();
		case ($urandom_range(0, 9))
			6, 7: return $urandom_range(0, 4095);
			8: return 4095 - $urandom_range(0, 3);
			9: return $urandom_range(0, 3);
			default: return $urandom_range(0, 40);
		endcase
	endfunction

	function automatic logic [SCALE_W-1:0] pick_scale();
		if ($urandom_range(0, 3) == 0)
			return SCALE_W'($urandom_range(0, 1048575));
		return SCALE_W'($urandom_range(8192, 262144));  // 1/8 .. 4
	endfunction

	function automatic logic [DIM_W-1:0] pick_extent();
		if ($urandom_range(0, 3) == 0)
			return DIM_W'($urandom_range(0, 511));
		return DIM_W'($urandom_range(1, 24));
	endfunction

	// Settings per phase: reset values first, then the corners, then random ones.
	function automatic irs_cfg_t pick_setting(int k);
		irs_cfg_t s;
		case (k)
			1: s = '{9'd4, 9'd3, 3'd2, MODE_BILINEAR, 20'd0, 20'hFFFFF};
			2: s = '{9'd256, 9'd256, 3'd4, MODE_NEAREST, 20'd1, 20'hFFFFF};
			3: s = '{9'd1, 9'd1, 3'd1, MODE_BILINEAR, 20'hFFFFF, 20'd1};
			4: s = '{9'd0, 9'd511, 3'd0, MODE_BILINEAR, 20'd65536, 20'd32768};
			5: s = '{9'd7, 9'd5, 3'd7, MODE_NEAREST, 20'd0, 20'd0};
			default: begin
				s.source_width = pick_extent();
				s.source_height = pick_extent();
				s.channel_count = CCNT_W'($urandom_range(0, 7));
				s.interp_mode = k[0] ? MODE_BILINEAR : MODE_NEAREST;
				s.x_scale = pick_scale();
				s.y_scale = pick_scale();
			end
		endcase
		return s;
	endfunction

	task automatic random_phase(int budget);
		int made, w, h, nc;
		made = 0;
		w = eff_extent(active_cfg.source_width, MAX_WIDTH);
		h = eff_extent(active_cfg.source_height, MAX_HEIGHT);
		nc = eff_extent(active_cfg.channel_count, MAX_CHANNELS);
		while (made < budget) begin
			if ($urandom_range(0, 99) < 30) begin
				case ($urandom_range(0, 9))
					7, 8: made += queue_load($urandom_range(0, MAX_WIDTH - 1),
						$urandom_range(0, MAX_HEIGHT - 1), $urandom_range(0, 3),
						$urandom_range(0, 255));
					// noise: anywhere in the field, often outside the store
					9: made += queue_load($urandom_range(0, 4095), $urandom_range(0, 4095),
						$urandom_range(0, 3), $urandom_range(0, 255));
					default: made += queue_load($urandom_range(0, w - 1),
						$urandom_range(0, h - 1), $urandom_range(0, nc - 1),
						$urandom_range(0, 255));
				endcase
			end else begin
				made += queue_pixel(pick_coord(), pick_coord(), $urandom_range(0, 3));
			end
		end
	endtask

	// ---------------------------------------------------------------------------------
	// Register writes and phase control
	// ---------------------------------------------------------------------------------

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_SOURCE_WIDTH: active_cfg.source_width = data[DIM_W-1:0];
			CFG_SOURCE_HEIGHT: active_cfg.source_height = data[DIM_W-1:0];
			CFG_CHANNEL_COUNT: active_cfg.channel_count = data[CCNT_W-1:0];
			CFG_INTERP_MODE: active_cfg.interp_mode = data[0];
			CFG_X_SCALE: active_cfg.x_scale = data[SCALE_W-1:0];
			CFG_Y_SCALE: active_cfg.y_scale = data[SCALE_W-1:0];
			default: ;  // unmapped index, nothing changes
		endcase
	endtask

	// Register value, half the time with random junk above its width; only the low bits may count.
	function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int width);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom) << width;
		return ($urandom_range(0, 1) == 0) ? v : (junk | v);
	endfunction

	task automatic apply_setting(input irs_cfg_t s);
		write_register(CFG_SOURCE_WIDTH, with_junk(s.source_width, DIM_W));
		write_register(CFG_SOURCE_HEIGHT, with_junk(s.source_height, DIM_W));
		write_register(CFG_CHANNEL_COUNT, with_junk(s.channel_count, CCNT_W));
		write_register(CFG_INTERP_MODE, with_junk(s.interp_mode, 1));
		write_register(CFG_X_SCALE, s.x_scale);
		write_register(CFG_Y_SCALE, s.y_scale);
		write_register(CFG_SPARE_LO, CFG_DATA_W'($urandom));
		write_register(CFG_SPARE_HI, CFG_DATA_W'($urandom));
	endtask

	// Sender holds off until every queued item went in and every pixel came back,
	// then lets the pipeline run dry (a trailing load leaves nothing to wait on).
	// Sampled on the falling edge so the clocked blocks have settled.
	task automatic wait_for_drain();
		@(negedge clk);
		while (pending_items.size() != 0 || push || expected_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------

	initial begin
		int made;
		made = 0;
		// reset values of the register file
		active_cfg = '{9'd256, 9'd256, 3'd3, MODE_NEAREST, 20'd65536, 20'd65536};
		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset settings: 256x256, 3 channels, nearest, unit scale.
		made += queue_load(4095, 4095, 3, 255);    // outside the store, dropped
		made += queue_load(MAX_WIDTH - 1, MAX_HEIGHT - 1, 3, 0);
		made += queue_load(0, 0, 0, 255);
		made += queue_load(MAX_WIDTH - 1, 0, 2, 128);
		made += queue_load(MAX_WIDTH, 0, 0, 77);   // column one past the store
		made += queue_load(0, MAX_HEIGHT, 1, 66);  // row one past the store
		made += queue_pixel(0, 0, 0);
		made += queue_pixel(MAX_WIDTH - 1, 0, 3);  // channel past count reads channel 2
		made += queue_pixel(4095, 4095, 3);        // clamps to the far corner
		made += queue_pixel(4095, 0, 0);
		made += queue_pixel(MAX_WIDTH - 1, MAX_HEIGHT - 1, 3);
		wait_for_drain();

		// Directed, small image, bilinear, zero x scale and largest y scale.
		apply_setting(pick_setting(1));
		@(negedge clk);
		made += queue_load(10, 10, 1, 200);        // beyond the image, still in the store
		made += queue_load(3, 2, 1, 255);
		made += queue_load(3, 2, 0, 0);
		made += queue_pixel(0, 0, 0);
		made += queue_pixel(4095, 4095, 3);
		made += queue_pixel(0, 4095, 1);
		made += queue_pixel(5, 1, 2);
		made += queue_pixel(10, 10, 1);

		for (int k = 2; k < PHASES; k++) begin
			wait_for_drain();
			apply_setting(pick_setting(k));
			@(negedge clk);
			if (k == PHASES - 1)
				calm = 1'b1;
			random_phase(PHASE_ITEMS);
		end

		wait_for_drain();
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------------------
	// Driver: feeds queued items, idles in random bursts between transfers
	// ---------------------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				predict_transfer(req);
			// an offered item stays up until it transfers
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_items.size() == 0) begin
					push <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					send_gap = $urandom_range(0, 16);
					push <= 1'b0;
				end else begin
					req <= pending_items.pop_front();
					push <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Monitor: pops results, stalls in random bursts, checks against oldest prediction
	// ---------------------------------------------------------------------------------

	always @(posedge clk or negedge arst_n) begin
		irs_rsp_t want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_pixels.size() == 0) begin
					$error("result with nothing pending: col %0d row %0d ch %0d value %0d",
						rsp.result_col, rsp.result_row, rsp.result_channel, rsp.result_value);
					error_count++;
				end else begin
					want = expected_pixels.pop_front();
					if (rsp.result_value !== want.result_value) begin
						$error("result_value: expected %0d, actual %0d",
							want.result_value, rsp.result_value);
						error_count++;
					end
					if (rsp.result_col !== want.result_col) begin
						$error("result_col: expected %0d, actual %0d",
							want.result_col, rsp.result_col);
						error_count++;
					end
					if (rsp.result_row !== want.result_row) begin
						$error("result_row: expected %0d, actual %0d",
							want.result_row, rsp.result_row);
						error_count++;
					end
					if (rsp.result_channel !== want.result_channel) begin
						$error("result_channel: expected %0d, actual %0d",
							want.result_channel, rsp.result_channel);
						error_count++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 15) == 0) begin
				recv_gap = $urandom_range(0, 16);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

endmodule
